>>> src/lmseq_pkg.sv
package lmseq_pkg;

    // Field widths fixed by the tap format
    localparam int TAP_W     = 24;
    localparam int SMP_W     = 16;
    localparam int MU_W      = 16;
    localparam int LANE_W    = 2;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;

    // Q3.20 constants
    localparam logic signed [TAP_W-1:0] ONE_Q320 = 24'sh100000;
    localparam logic signed [TAP_W-1:0] TAP_MAX  = 24'sh7FFFFF;
    localparam logic signed [TAP_W-1:0] TAP_MIN  = 24'sh800000;

    // Step size reset values (Q0.16)
    localparam logic [MU_W-1:0] MU_FFE_RST = 16'd655;
    localparam logic [MU_W-1:0] MU_DFE_RST = 16'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MU_FFE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MU_DFE = 2'd1;

    // One input transaction
    typedef struct packed {
        logic [LANE_W-1:0]       lane;
        logic [IDX_W-1:0]        tap_index;
        logic signed [SMP_W-1:0] err_value;
        logic signed [SMP_W-1:0] sample;
        logic                    reset_taps;
        logic                    last_element;
    } t_in_item;

    // One result transaction
    typedef struct packed {
        logic [LANE_W-1:0]       out_lane;
        logic [IDX_W-1:0]        out_index;
        logic signed [TAP_W-1:0] tap_value;
        logic                    was_restored;
        logic                    saturated;
        logic                    out_last;
    } t_out_item;

    // Control that travels with an item down the pipeline
    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic [IDX_W-1:0]  tap_index;
        logic              reset_taps;
        logic              last;
        logic              hit;
        logic              is_ffe;
        logic              is_center;
    } t_meta;

endpackage

>>> src/lmseq_ram.sv
module lmseq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 45,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port, registered read of the old contents
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/lmseq_step.sv
module lmseq_step (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [lmseq_pkg::SMP_W-1:0]  i_err,
    input  logic signed [lmseq_pkg::SMP_W-1:0]  i_sample,
    input  logic [lmseq_pkg::MU_W-1:0]          i_mu,
    output logic signed [lmseq_pkg::TAP_W-1:0]  o_step
);

    localparam int P1_W = 2 * lmseq_pkg::SMP_W;
    localparam int P2_W = P1_W + lmseq_pkg::MU_W + 1;
    localparam int SHIFT = 24;

    logic signed [P1_W-1:0] n_prod1;
    logic signed [P1_W-1:0] r_prod1;
    logic signed [P2_W-1:0] n_prod2;
    logic signed [P2_W-1:0] r_prod2;
    logic signed [P2_W-1:0] n_round;
    logic signed [lmseq_pkg::TAP_W-1:0] r_step;

    // err * sample, then mu * (err * sample), then round half up to Q3.20
    assign n_prod1 = i_err * i_sample;
    assign n_prod2 = $signed({1'b0, i_mu}) * r_prod1;
    assign n_round = r_prod2 + (P2_W'(1) <<< (SHIFT - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod1 <= n_prod1;
            r_prod2 <= n_prod2;
            r_step  <= n_round[SHIFT + lmseq_pkg::TAP_W - 1:SHIFT];
        end
    end

    assign o_step = r_step;

endmodule

>>> src/lms_equalizer_tap_update_top.sv
// LMS tap store for an FFE plus DFE equalizer with LANES lanes. Each input
// transaction names one tap (lane, tap_index), optionally restores it to its
// identity value (1.0 at CENTER_TAP, 0 elsewhere), adds mu_ffe*err*sample to
// an FFE tap or subtracts mu_dfe*err*sample from a DFE tap, saturates to
// Q3.20 and returns the new tap. One transaction is accepted per cycle while
// the output is not stalled; each result passes three register stages for
// the two multiplies and the rounding, then the read-modify-write of the tap
// store feeds the output register. A stalled output freezes the whole
// pipeline. Back-to-back updates of the same tap are forwarded, so no spacing
// is needed between them. After reset every tap reads as its identity value
// at once. Taps with a lane or index out of range return zero tap_value and
// flags and change nothing. Write mu_ffe (index 0) and mu_dfe (index 1) only
// while the block is idle; the configuration port is always ready.
module lms_equalizer_tap_update_top #(
    parameter int LANES      = 3,
    parameter int FFE_TAPS   = 14,
    parameter int CENTER_TAP = 3,
    parameter int DFE_TAPS   = 1
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  lmseq_pkg::t_in_item                i_data,
    output logic                               o_valid,
    input  logic                               i_stall,
    output lmseq_pkg::t_out_item               o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lmseq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lmseq_pkg::MU_W-1:0]         i_cfg_data
);

    localparam int TPL   = FFE_TAPS + DFE_TAPS;
    localparam int DEPTH = LANES * TPL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = lmseq_pkg::TAP_W;

    logic en;

    // Step size registers
    logic [lmseq_pkg::MU_W-1:0] r_mu_ffe;
    logic [lmseq_pkg::MU_W-1:0] r_mu_dfe;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mu_ffe <= lmseq_pkg::MU_FFE_RST;
            r_mu_dfe <= lmseq_pkg::MU_DFE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lmseq_pkg::CFG_MU_FFE: r_mu_ffe <= i_cfg_data;
                lmseq_pkg::CFG_MU_DFE: r_mu_dfe <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance the whole pipeline unless a result waits at a stalled output
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // Decode the tap address on entry
    lmseq_pkg::t_meta n_s1_meta;
    logic [AW-1:0]    n_s1_addr;

    always_comb begin
        n_s1_meta.lane       = i_data.lane;
        n_s1_meta.tap_index  = i_data.tap_index;
        n_s1_meta.reset_taps = i_data.reset_taps;
        n_s1_meta.last       = i_data.last_element;
        n_s1_meta.hit        = (32'(i_data.lane) < LANES) && (32'(i_data.tap_index) < TPL);
        n_s1_meta.is_ffe     = 32'(i_data.tap_index) < FFE_TAPS;
        n_s1_meta.is_center  = (32'(i_data.tap_index) == CENTER_TAP) &&
                               (32'(i_data.tap_index) < FFE_TAPS);
        n_s1_addr = AW'(32'(i_data.lane) * TPL + 32'(i_data.tap_index));
    end

    // Control stages that run alongside the step multiplier
    logic               r_s1_valid, r_s2_valid, r_s3_valid;
    lmseq_pkg::t_meta   r_s1_meta, r_s2_meta, r_s3_meta;
    logic [AW-1:0]      r_s1_addr, r_s2_addr, r_s3_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_meta <= n_s1_meta;
            r_s1_addr <= n_s1_addr;
            r_s2_meta <= r_s1_meta;
            r_s2_addr <= r_s1_addr;
            r_s3_meta <= r_s2_meta;
            r_s3_addr <= r_s2_addr;
        end
    end

    // Step pipeline: result lines up with stage 3
    logic signed [TW-1:0] s3_step;

    lmseq_step u_step (
        .i_clk    (i_clk),
        .i_en     (en),
        .i_err    (i_data.err_value),
        .i_sample (i_data.sample),
        .i_mu     (r_s1_meta.is_ffe ? r_mu_ffe : r_mu_dfe),
        .o_step   (s3_step)
    );

    // Tap store: read for stage 2, data arrives with stage 3; while stalled,
    // hold the read on the waiting stage-3 item
    logic            s3_we;
    logic [TW-1:0]   s3_rdata;
    logic [TW-1:0]   s3_wdata;
    logic [AW-1:0]   rd_addr;

    assign rd_addr = en ? r_s2_addr : r_s3_addr;

    lmseq_ram #(
        .WIDTH (TW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s3_we),
        .i_waddr (r_s3_addr),
        .i_wdata (s3_wdata),
        .i_raddr (rd_addr),
        .o_rdata (s3_rdata)
    );

    // Written marks: an unwritten tap reads as its identity value
    logic [DEPTH-1:0] r_written;
    logic             r_s3_written;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (s3_we) begin
            r_written[r_s3_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_written <= r_written[rd_addr];
    end

    // Forward a write that lands as the next item of the same tap reads
    logic                 r_s3_byp;
    logic signed [TW-1:0] r_s3_byp_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_byp <= 1'b0;
        end else if (en) begin
            r_s3_byp <= s3_we && (r_s3_addr == r_s2_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_byp_val <= s3_wdata;
        end
    end

    // Update the tap and saturate
    logic signed [TW-1:0] s3_ident;
    logic signed [TW-1:0] s3_tap;
    logic signed [TW:0]   s3_sum;
    logic signed [TW-1:0] s3_sat_val;
    logic                 s3_clip;

    always_comb begin
        s3_ident = r_s3_meta.is_center ? lmseq_pkg::ONE_Q320 : '0;
        if (r_s3_meta.reset_taps) begin
            s3_tap = s3_ident;
        end else if (r_s3_byp) begin
            s3_tap = r_s3_byp_val;
        end else if (r_s3_written) begin
            s3_tap = $signed(s3_rdata);
        end else begin
            s3_tap = s3_ident;
        end

        if (r_s3_meta.is_ffe) begin
            s3_sum = (TW+1)'(s3_tap) + (TW+1)'(s3_step);
        end else begin
            s3_sum = (TW+1)'(s3_tap) - (TW+1)'(s3_step);
        end

        if (s3_sum > (TW+1)'(lmseq_pkg::TAP_MAX)) begin
            s3_sat_val = lmseq_pkg::TAP_MAX;
            s3_clip    = 1'b1;
        end else if (s3_sum < (TW+1)'(lmseq_pkg::TAP_MIN)) begin
            s3_sat_val = lmseq_pkg::TAP_MIN;
            s3_clip    = 1'b1;
        end else begin
            s3_sat_val = s3_sum[TW-1:0];
            s3_clip    = 1'b0;
        end
    end

    assign s3_we    = en && r_s3_valid && r_s3_meta.hit;
    assign s3_wdata = s3_sat_val;

    // Output register
    logic                 r_o_valid;
    lmseq_pkg::t_out_item r_o_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_item.out_lane     <= r_s3_meta.lane;
            r_o_item.out_index    <= r_s3_meta.tap_index;
            r_o_item.out_last     <= r_s3_meta.last;
            r_o_item.tap_value    <= r_s3_meta.hit ? s3_sat_val : '0;
            r_o_item.was_restored <= r_s3_meta.hit && r_s3_meta.reset_taps;
            r_o_item.saturated    <= r_s3_meta.hit && s3_clip;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_o_item;

endmodule

>>> tb/tb_lms_equalizer_tap_update_top.sv
`timescale 1ns / 100ps

module tb_lms_equalizer_tap_update_top;

    localparam int LANES      = 3;
    localparam int FFE_TAPS   = 14;
    localparam int CENTER_TAP = 3;
    localparam int DFE_TAPS   = 1;
    localparam int LANE_TAPS  = FFE_TAPS + DFE_TAPS;
    localparam int STORE_SIZE = LANES * LANE_TAPS;

    // Spare register indexes: writes there must be ignored
    localparam logic [lmseq_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [lmseq_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [lmseq_pkg::SMP_W-1:0] Q14_MAX = 16'h7FFF;
    localparam logic [lmseq_pkg::SMP_W-1:0] Q14_MIN = 16'h8000;
    localparam logic [lmseq_pkg::MU_W-1:0]  MU_MAX  = 16'hFFFF;

    localparam int SHOW_LIMIT  = 10;
    localparam int STUCK_LIMIT = 4000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    lmseq_pkg::t_in_item  i_data      = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    lmseq_pkg::t_out_item o_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [lmseq_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [lmseq_pkg::MU_W-1:0]      i_cfg_data  = '0;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int stuck_count = 0;

    // Tap store model and queue of predicted tap updates
    class t_tap_scoreboard;
        logic signed [lmseq_pkg::TAP_W-1:0] tap_mem [STORE_SIZE];
        logic [lmseq_pkg::MU_W-1:0] mu_ffe;
        logic [lmseq_pkg::MU_W-1:0] mu_dfe;
        lmseq_pkg::t_out_item       pending_taps [$];
        int                         errors;
        int                         shown;

        function new();
            for (int k = 0; k < STORE_SIZE; k++) begin
                tap_mem[k] = identity_tap(k % LANE_TAPS);
            end
            mu_ffe = lmseq_pkg::MU_FFE_RST;
            mu_dfe = lmseq_pkg::MU_DFE_RST;
            errors = 0;
            shown  = 0;
        endfunction

        function logic signed [lmseq_pkg::TAP_W-1:0] identity_tap(int idx);
            return (idx < FFE_TAPS && idx == CENTER_TAP) ? lmseq_pkg::ONE_Q320 : '0;
        endfunction

        function void write_reg(logic [lmseq_pkg::CFG_IDX_W-1:0] idx,
                                logic [lmseq_pkg::MU_W-1:0] val);
            case (idx)
                lmseq_pkg::CFG_MU_FFE: mu_ffe = val;
                lmseq_pkg::CFG_MU_DFE: mu_dfe = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_taps.size();
        endfunction

        // Predict the updated tap for one accepted input transaction
        function void note_update(lmseq_pkg::t_in_item it);
            lmseq_pkg::t_out_item               r;
            logic signed [lmseq_pkg::TAP_W-1:0] tap;
            longint                             prod;
            longint                             step;
            longint                             sum;
            int                                 pos;
            bit                                 is_ffe;
            r           = '0;
            r.out_lane  = it.lane;
            r.out_index = it.tap_index;
            r.out_last  = it.last_element;
            if (it.lane < LANES && it.tap_index < LANE_TAPS) begin
                pos    = it.lane * LANE_TAPS + it.tap_index;
                is_ffe = it.tap_index < FFE_TAPS;
                tap    = tap_mem[pos];
                if (it.reset_taps) begin
                    tap            = identity_tap(int'(it.tap_index));
                    r.was_restored = 1'b1;
                end
                prod = longint'(is_ffe ? mu_ffe : mu_dfe) * longint'($signed(it.err_value))
                       * longint'($signed(it.sample));
                // round half up from 44 to 20 fraction bits
                step = (prod + 64'sd8388608) >>> 24;
                sum  = is_ffe ? longint'(tap) + step : longint'(tap) - step;
                if (sum > longint'(lmseq_pkg::TAP_MAX)) begin
                    sum         = longint'(lmseq_pkg::TAP_MAX);
                    r.saturated = 1'b1;
                end else if (sum < longint'(lmseq_pkg::TAP_MIN)) begin
                    sum         = longint'(lmseq_pkg::TAP_MIN);
                    r.saturated = 1'b1;
                end
                tap_mem[pos] = sum[lmseq_pkg::TAP_W-1:0];
                r.tap_value  = sum[lmseq_pkg::TAP_W-1:0];
            end
            pending_taps.push_back(r);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_result(lmseq_pkg::t_out_item got);
            lmseq_pkg::t_out_item want;
            if (pending_taps.size() == 0) begin
                errors++;
                if (shown < SHOW_LIMIT) begin
                    shown++;
                    $display("ERROR: unexpected result lane=%0d idx=%0d tap=%h",
                             got.out_lane, got.out_index, got.tap_value);
                end
                return;
            end
            want = pending_taps.pop_front();
            if (got.out_lane !== want.out_lane || got.out_index !== want.out_index ||
                got.tap_value !== want.tap_value ||
                got.was_restored !== want.was_restored ||
                got.saturated !== want.saturated || got.out_last !== want.out_last) begin
                errors++;
                if (shown < SHOW_LIMIT) begin
                    shown++;
                    $display("ERROR: expected lane=%0d idx=%0d tap=%h rst=%b sat=%b last=%b",
                             want.out_lane, want.out_index, want.tap_value,
                             want.was_restored, want.saturated, want.out_last);
                    $display("       actual   lane=%0d idx=%0d tap=%h rst=%b sat=%b last=%b",
                             got.out_lane, got.out_index, got.tap_value,
                             got.was_restored, got.saturated, got.out_last);
                end
            end
        endfunction
    endclass

    t_tap_scoreboard sb = new();

    lms_equalizer_tap_update_top #(
        .LANES      (LANES),
        .FFE_TAPS   (FFE_TAPS),
        .CENTER_TAP (CENTER_TAP),
        .DFE_TAPS   (DFE_TAPS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Apply receiver back-pressure
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // Observe every transaction at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
            if (i_valid && !o_stall) begin
                sb.note_update(i_data);
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_data);
            end
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stuck_count <= 0;
        end else begin
            stuck_count <= stuck_count + 1;
        end
        if (stuck_count >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic lmseq_pkg::t_in_item make_item(int lane, int idx,
                                                      logic [lmseq_pkg::SMP_W-1:0] err,
                                                      logic [lmseq_pkg::SMP_W-1:0] smp,
                                                      bit rst, bit last);
        lmseq_pkg::t_in_item it;
        it.lane         = lmseq_pkg::LANE_W'(lane);
        it.tap_index    = lmseq_pkg::IDX_W'(idx);
        it.err_value    = err;
        it.sample       = smp;
        it.reset_taps   = rst;
        it.last_element = last;
        return it;
    endfunction

    function automatic logic [lmseq_pkg::SMP_W-1:0] pick_q14();
        case ($urandom_range(9))
            0: return Q14_MIN;
            1: return Q14_MAX;
            2: return '0;
            default: return lmseq_pkg::SMP_W'($urandom);
        endcase
    endfunction

    // Drive one input transaction, with random idle cycles ahead of it
    task automatic send_item(lmseq_pkg::t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Wait for the pipeline to drain, then write both step sizes and a spare index
    task automatic write_step_sizes(logic [lmseq_pkg::MU_W-1:0] mu_f,
                                    logic [lmseq_pkg::MU_W-1:0] mu_d);
        logic [lmseq_pkg::CFG_IDX_W-1:0] idx_list [3];
        logic [lmseq_pkg::MU_W-1:0]      val_list [3];
        idx_list = '{lmseq_pkg::CFG_MU_FFE, lmseq_pkg::CFG_MU_DFE,
                     $urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B};
        val_list = '{mu_f, mu_d, lmseq_pkg::MU_W'($urandom)};
        while (sb.pending() != 0) @(negedge i_clk);
        for (int w = 0; w < 3; w++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_list[w];
            i_cfg_data  <= val_list[w];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic: lane packets, bursts on one tap, and stray items
    task automatic run_phase(int n_items, int idle, int stall);
        int count;
        int lane;
        int len;
        int start;
        int hot_lane;
        int hot_idx;
        bit hot_neg;
        logic [lmseq_pkg::SMP_W-1:0] mag;
        idle_pct  = idle;
        stall_pct = stall;
        count     = 0;
        hot_lane  = $urandom_range(LANES - 1);
        hot_idx   = $urandom_range(LANE_TAPS - 1);
        hot_neg   = $urandom_range(1);
        while (count < n_items) begin
            case ($urandom_range(99)) inside
                [0:69]: begin
                    lane  = $urandom_range(LANES - 1);
                    len   = $urandom_range(1, LANE_TAPS);
                    start = $urandom_range(LANE_TAPS - 1);
                    for (int k = 0; k < len; k++) begin
                        send_item(make_item(lane, (start + k) % LANE_TAPS, pick_q14(),
                                            pick_q14(), $urandom_range(99) < 8,
                                            k == len - 1));
                    end
                    count += len;
                end
                [70:84]: begin
                    // push one tap hard toward a rail
                    for (int k = 0; k < 6; k++) begin
                        mag = lmseq_pkg::SMP_W'(20000 + $urandom_range(12767));
                        send_item(make_item(hot_lane, hot_idx, mag, hot_neg ? ~mag : mag,
                                            $urandom_range(99) < 3, k == 5));
                    end
                    count += 6;
                end
                default: begin
                    send_item(make_item($urandom_range(3), $urandom_range(15), pick_q14(),
                                        pick_q14(), $urandom_range(1), $urandom_range(1)));
                    count++;
                end
            endcase
        end
        i_valid <= 1'b0;
    endtask

    task automatic run_directed(ref lmseq_pkg::t_in_item items [$]);
        foreach (items[k]) send_item(items[k]);
        i_valid <= 1'b0;
    endtask

    initial begin
        lmseq_pkg::t_in_item dir_q [$];

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset step sizes: identity taps, extreme operands, out-of-range addresses
        dir_q.push_back(make_item(0, CENTER_TAP, '0, '0, 0, 0));
        dir_q.push_back(make_item(0, 0, Q14_MAX, Q14_MAX, 0, 0));
        dir_q.push_back(make_item(0, 0, Q14_MIN, Q14_MIN, 0, 0));
        dir_q.push_back(make_item(0, 0, Q14_MIN, Q14_MAX, 0, 0));
        dir_q.push_back(make_item(1, FFE_TAPS - 1, Q14_MAX, Q14_MIN, 0, 1));
        dir_q.push_back(make_item(2, FFE_TAPS, Q14_MAX, Q14_MAX, 0, 0));
        dir_q.push_back(make_item(2, CENTER_TAP, 16'h1234, 16'hC321, 1, 0));
        dir_q.push_back(make_item(3, 0, Q14_MAX, Q14_MAX, 0, 0));
        dir_q.push_back(make_item(0, 15, Q14_MAX, Q14_MAX, 1, 1));
        dir_q.push_back(make_item(3, 15, Q14_MIN, Q14_MIN, 1, 1));
        dir_q.push_back(make_item(1, CENTER_TAP, '0, '0, 1, 0));
        dir_q.push_back(make_item(0, 0, 16'h0001, 16'h0001, 0, 1));
        run_directed(dir_q);

        // Largest step sizes: drive taps into both rails
        write_step_sizes(MU_MAX, MU_MAX);
        dir_q.delete();
        for (int k = 0; k < 3; k++) dir_q.push_back(make_item(0, 5, Q14_MAX, Q14_MAX, 0, k == 2));
        for (int k = 0; k < 5; k++) dir_q.push_back(make_item(0, 5, Q14_MIN, Q14_MAX, 0, k == 4));
        for (int k = 0; k < 3; k++) dir_q.push_back(make_item(1, FFE_TAPS, Q14_MAX, Q14_MAX, 0, 0));
        dir_q.push_back(make_item(1, FFE_TAPS, Q14_MAX, Q14_MAX, 1, 1));
        dir_q.push_back(make_item(2, CENTER_TAP, Q14_MIN, Q14_MIN, 1, 1));
        run_directed(dir_q);

        // Random phases across step-size settings and idle and stall patterns
        run_phase(150, 0, 0);
        write_step_sizes('0, '0);
        run_phase(100, 79, 0);
        write_step_sizes(16'd1, 16'd1);
        run_phase(100, 0, 79);
        write_step_sizes(16'd4096, 16'd20000);
        run_phase(150, 10, 10);
        write_step_sizes(lmseq_pkg::MU_W'($urandom), lmseq_pkg::MU_W'($urandom));
        run_phase(150, 0, 0);
        write_step_sizes(MU_MAX, '0);
        run_phase(100, 79, 0);
        write_step_sizes(16'h8000, MU_MAX);
        run_phase(100, 0, 79);
        write_step_sizes(lmseq_pkg::MU_W'($urandom), lmseq_pkg::MU_W'($urandom));
        run_phase(100, 10, 10);

        // Drain, then watch for stray results
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
